>>> rtl/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;

  localparam int unsigned ROOT_W = 17;
  localparam int unsigned DISC_W = 34;

  typedef enum logic [1:0] {
    CLS_TWO     = 2'd0,
    CLS_DOUBLE  = 2'd1,
    CLS_COMPLEX = 2'd2
  } disc_class_e;

  typedef struct packed {
    logic        vld;
    disc_class_e cls;
  } info_t;

endpackage

>>> rtl/qrs_if.sv
`timescale 1ns / 1ps
interface coef_if #(
  parameter int unsigned W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface root_if import qrs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ROOT_W-1:0] root_plus;
  logic signed [ROOT_W-1:0] root_minus;
  logic signed [DISC_W-1:0] disc_value;
  logic [1:0]               disc_class;
  logic                     roots_valid;

  modport source (output valid, root_plus, root_minus, disc_value, disc_class, roots_valid,
                  input ready);
  modport sink   (input valid, root_plus, root_minus, disc_value, disc_class, roots_valid,
                  output ready);
endinterface

>>> rtl/qrs_disc.sv
`timescale 1ns / 1ps
module qrs_disc import qrs_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic signed [W-1:0]   c_i,
  output logic                  valid_o,
  output logic signed [W-1:0]   a_o,
  output logic signed [W-1:0]   b_o,
  output logic signed [2*W+1:0] d_o,
  output info_t                 info_o
);
  localparam int unsigned DW = 2 * W + 2;

  logic                  v1_q, v2_q;
  logic signed [W-1:0]   a1_q, b1_q, a2_q, b2_q;
  logic signed [2*W-1:0] bb_q, ac_q;
  logic signed [DW-1:0]  d_d, d_q;
  info_t                 info_d, info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q   <= b_i * b_i;
      ac_q   <= a_i * c_i;
      a1_q   <= a_i;
      b1_q   <= b_i;
      d_q    <= d_d;
      info_q <= info_d;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
    end
  end

  always_comb begin
    d_d = DW'(bb_q) - $signed({ac_q, 2'b00});
    if (d_d[DW-1]) begin
      info_d.cls = CLS_COMPLEX;
    end else if (d_d == '0) begin
      info_d.cls = CLS_DOUBLE;
    end else begin
      info_d.cls = CLS_TWO;
    end
    info_d.vld = (a1_q != '0) && !d_d[DW-1];
  end

  assign valid_o = v2_q;
  assign a_o     = a2_q;
  assign b_o     = b2_q;
  assign d_o     = d_q;
  assign info_o  = info_q;
endmodule

>>> rtl/qrs_sqrt.sv
`timescale 1ns / 1ps
module qrs_sqrt import qrs_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic signed [2*W+1:0] d_i,
  input  info_t                 info_i,
  output logic                  valid_o,
  output logic signed [W-1:0]   a_o,
  output logic signed [W-1:0]   b_o,
  output logic signed [2*W+1:0] d_o,
  output info_t                 info_o,
  output logic [W:0]            s_o,
  output logic                  exact_o
);
  localparam int unsigned DW = 2 * W + 2;
  localparam int unsigned SW = W + 1;
  localparam int unsigned RW = SW + 3;

  logic                 v   [SW+1];
  logic signed [W-1:0]  a   [SW+1];
  logic signed [W-1:0]  b   [SW+1];
  logic signed [DW-1:0] d   [SW+1];
  info_t                inf [SW+1];
  logic [DW-1:0]        bits[SW+1];
  logic [RW-1:0]        rem [SW+1];
  logic [SW-1:0]        root[SW+1];

  assign v[0]    = valid_i;
  assign a[0]    = a_i;
  assign b[0]    = b_i;
  assign d[0]    = d_i;
  assign inf[0]  = info_i;
  assign bits[0] = d_i;
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RW-1:0] cur, trial;
    assign cur   = {rem[k][RW-3:0], bits[k][DW-1:DW-2]};
    assign trial = RW'({root[k], 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a[k+1]    <= a[k];
        b[k+1]    <= b[k];
        d[k+1]    <= d[k];
        inf[k+1]  <= inf[k];
        bits[k+1] <= {bits[k][DW-3:0], 2'b00};
        if (cur >= trial) begin
          rem[k+1]  <= cur - trial;
          root[k+1] <= {root[k][SW-2:0], 1'b1};
        end else begin
          rem[k+1]  <= cur;
          root[k+1] <= {root[k][SW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v[SW];
  assign a_o     = a[SW];
  assign b_o     = b[SW];
  assign d_o     = d[SW];
  assign info_o  = inf[SW];
  assign s_o     = root[SW];
  assign exact_o = (rem[SW] == '0);
endmodule

>>> rtl/qrs_div.sv
`timescale 1ns / 1ps
module qrs_div import qrs_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic signed [2*W+1:0] d_i,
  input  info_t                 info_i,
  input  logic [W:0]            s_i,
  input  logic                  exact_i,
  output logic                  valid_o,
  output logic signed [2*W+1:0] d_o,
  output info_t                 info_o,
  output logic [W+1:0]          quo_p_o,
  output logic [W+1:0]          quo_m_o,
  output logic                  neg_p_o,
  output logic                  neg_m_o
);
  localparam int unsigned DW  = 2 * W + 2;
  localparam int unsigned NW  = W + 2;
  localparam int unsigned QW  = W + 1;
  localparam int unsigned RDW = QW + 1;

  // numerator magnitude and sign per root
  logic signed [W+2:0] p, sx, scx, lo_p, hi_p, lo_m, hi_m, nh_p, nh_m;
  logic [W-1:0]        mag;
  logic [NW-1:0]       n_p_d, n_m_d;
  logic                neg_p_d, neg_m_d;

  always_comb begin
    p   = a_i[W-1] ? (W+3)'(b_i) : -((W+3)'(b_i));
    mag = a_i[W-1] ? W'(-a_i) : W'(a_i);
    sx  = $signed({2'b00, s_i});
    scx = exact_i ? sx : sx + (W+3)'(1);
    if (!a_i[W-1]) begin
      lo_p = p + sx;
      hi_p = p + scx;
      lo_m = p - scx;
      hi_m = p - sx;
    end else begin
      lo_p = p - scx;
      hi_p = p - sx;
      lo_m = p + sx;
      hi_m = p + scx;
    end
    nh_p    = -hi_p;
    nh_m    = -hi_m;
    neg_p_d = lo_p[W+2];
    neg_m_d = lo_m[W+2];
    n_p_d   = neg_p_d ? nh_p[NW-1:0] : lo_p[NW-1:0];
    n_m_d   = neg_m_d ? nh_m[NW-1:0] : lo_m[NW-1:0];
  end

  logic                 v    [NW+1];
  logic signed [DW-1:0] d    [NW+1];
  info_t                inf  [NW+1];
  logic [QW-1:0]        q    [NW+1];
  logic                 ngp  [NW+1];
  logic                 ngm  [NW+1];
  logic [NW-1:0]        np   [NW+1];
  logic [NW-1:0]        nm   [NW+1];
  logic [RDW-1:0]       rp   [NW+1];
  logic [RDW-1:0]       rm   [NW+1];
  logic [NW-1:0]        qp   [NW+1];
  logic [NW-1:0]        qm   [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v[0] <= 1'b0;
    end else if (en_i) begin
      v[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d[0]   <= d_i;
      inf[0] <= info_i;
      q[0]   <= {mag, 1'b0};
      ngp[0] <= neg_p_d;
      ngm[0] <= neg_m_d;
      np[0]  <= n_p_d;
      nm[0]  <= n_m_d;
      rp[0]  <= '0;
      rm[0]  <= '0;
      qp[0]  <= '0;
      qm[0]  <= '0;
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [RDW-1:0] cp, cm;
    assign cp = {rp[k][RDW-2:0], np[k][NW-1]};
    assign cm = {rm[k][RDW-2:0], nm[k][NW-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en_i) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d[k+1]   <= d[k];
        inf[k+1] <= inf[k];
        q[k+1]   <= q[k];
        ngp[k+1] <= ngp[k];
        ngm[k+1] <= ngm[k];
        np[k+1]  <= {np[k][NW-2:0], 1'b0};
        nm[k+1]  <= {nm[k][NW-2:0], 1'b0};
        if (cp >= RDW'(q[k])) begin
          rp[k+1] <= cp - RDW'(q[k]);
          qp[k+1] <= {qp[k][NW-2:0], 1'b1};
        end else begin
          rp[k+1] <= cp;
          qp[k+1] <= {qp[k][NW-2:0], 1'b0};
        end
        if (cm >= RDW'(q[k])) begin
          rm[k+1] <= cm - RDW'(q[k]);
          qm[k+1] <= {qm[k][NW-2:0], 1'b1};
        end else begin
          rm[k+1] <= cm;
          qm[k+1] <= {qm[k][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v[NW];
  assign d_o     = d[NW];
  assign info_o  = inf[NW];
  assign quo_p_o = qp[NW];
  assign quo_m_o = qm[NW];
  assign neg_p_o = ngp[NW];
  assign neg_m_o = ngm[NW];
endmodule

>>> rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps
// channel   dir  handshake     beat
// coef_i    in   valid/ready   coef_a, coef_b, coef_c
// root_o    out  valid/ready   root_plus, root_minus, disc_value, disc_class, roots_valid
//
// one beat accepted per cycle while root_o.ready or output register is empty; stages:
// 2 discriminant, COEF_WIDTH+1 square root, COEF_WIDTH+3 division, 1 output register
// the whole pipeline advances together; a stalled output freezes every stage
// reset clears only the stage valid bits
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int unsigned COEF_WIDTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  coef_if.sink   coef_i,
  root_if.source root_o
);
  localparam int unsigned W  = COEF_WIDTH;
  localparam int unsigned DW = 2 * W + 2;

  logic en;

  logic                 v1, v2, v3;
  logic signed [W-1:0]  a1, b1, a2, b2;
  logic signed [DW-1:0] d1, d2, d3;
  info_t                i1, i2, i3;
  logic [W:0]           s2;
  logic                 ex2;
  logic [W+1:0]         qp, qm;
  logic                 ngp, ngm;

  logic                     out_v_q;
  logic signed [ROOT_W-1:0] rp_q, rm_q;
  logic signed [DISC_W-1:0] disc_q;
  disc_class_e              cls_q;
  logic                     rv_q;
  logic signed [W+2:0]      rp_d, rm_d;

  assign en           = !out_v_q || root_o.ready;
  assign coef_i.ready = en;

  qrs_disc #(.W(W)) u_disc (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(coef_i.valid),
    .a_i(W'(coef_i.coef_a)), .b_i(W'(coef_i.coef_b)), .c_i(W'(coef_i.coef_c)),
    .valid_o(v1), .a_o(a1), .b_o(b1), .d_o(d1), .info_o(i1)
  );

  qrs_sqrt #(.W(W)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1), .a_i(a1), .b_i(b1), .d_i(d1), .info_i(i1),
    .valid_o(v2), .a_o(a2), .b_o(b2), .d_o(d2), .info_o(i2),
    .s_o(s2), .exact_o(ex2)
  );

  qrs_div #(.W(W)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v2), .a_i(a2), .b_i(b2), .d_i(d2), .info_i(i2),
    .s_i(s2), .exact_i(ex2),
    .valid_o(v3), .d_o(d3), .info_o(i3),
    .quo_p_o(qp), .quo_m_o(qm), .neg_p_o(ngp), .neg_m_o(ngm)
  );

  always_comb begin
    rp_d = ngp ? -$signed({1'b0, qp}) : $signed({1'b0, qp});
    rm_d = ngm ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rp_q   <= i3.vld ? ROOT_W'(rp_d) : '0;
      rm_q   <= i3.vld ? ROOT_W'(rm_d) : '0;
      disc_q <= DISC_W'(d3);
      cls_q  <= i3.cls;
      rv_q   <= i3.vld;
    end
  end

  assign root_o.valid       = out_v_q;
  assign root_o.root_plus   = rp_q;
  assign root_o.root_minus  = rm_q;
  assign root_o.disc_value  = disc_q;
  assign root_o.disc_class  = cls_q;
  assign root_o.roots_valid = rv_q;
endmodule
